>>> rtl/u2h_pkg.sv
// Package for the UTF-8 to UCS-2 hex encoder.
// Holds the shared types, lead-byte limits and the hex digit function.
// No dependencies.
package u2h_pkg;

    localparam int CODE_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;

    localparam logic [BYTE_W-1:0] LEAD_TWO_MIN   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_THREE_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_BAD_MIN   = 8'hF0;

    localparam logic [1:0] REM_NONE = 2'd0;
    localparam logic [1:0] REM_ONE  = 2'd1;
    localparam logic [1:0] REM_TWO  = 2'd2;

    localparam logic [1:0] DIGIT_LAST = 2'd3;

    // One finished character code on its way from the decoder to the queue.
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } code_push_t;

    // Fill status of the code queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Upper-case ASCII hex digit for one nibble.
    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nibble);
        logic [CHAR_W-1:0] result;
        if (nibble < 4'd10)
        begin
            result = 7'h30 + {3'b000, nibble};
        end
        else
        begin
            result = 7'h37 + {3'b000, nibble};
        end
        return result;
    endfunction

endpackage

>>> rtl/u2h_front.sv
// Front part of the encoder: accepts UTF-8 bytes and rebuilds character codes.
// Depends on u2h_pkg; pushes finished codes toward u2h_queue.
module u2h_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [u2h_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          start_of_text,
    output u2h_pkg::code_push_t           push
);

    logic [u2h_pkg::CODE_W-1:0] acc_reg;
    logic [u2h_pkg::CODE_W-1:0] acc_next;
    logic [1:0]                 rem_reg;
    logic [1:0]                 rem_next;

    logic [u2h_pkg::CODE_W-1:0] acc_cur;
    logic [1:0]                 rem_cur;
    logic [5:0]                 cont_bits;

    assign cont_bits = data_byte[5:0];

    always_comb
    begin
        // A start-of-text flag drops any partial sequence before this byte.
        acc_cur   = start_of_text ? '0 : acc_reg;
        rem_cur   = start_of_text ? u2h_pkg::REM_NONE : rem_reg;
        acc_next  = acc_cur;
        rem_next  = rem_cur;
        push      = '0;
        push.code = acc_cur;

        case (rem_cur)
            u2h_pkg::REM_TWO:
            begin
                acc_next = acc_cur | {4'b0000, cont_bits, 6'b000000};
                rem_next = u2h_pkg::REM_ONE;
            end
            u2h_pkg::REM_ONE:
            begin
                push.valid = 1'b1;
                push.code  = acc_cur | {10'b0, cont_bits};
                acc_next   = '0;
                rem_next   = u2h_pkg::REM_NONE;
            end
            u2h_pkg::REM_NONE:
            begin
                if (data_byte < u2h_pkg::LEAD_TWO_MIN)
                begin
                    push.valid = 1'b1;
                    push.code  = {8'h00, data_byte};
                    acc_next   = '0;
                end
                else if (data_byte < u2h_pkg::LEAD_THREE_MIN)
                begin
                    acc_next = {5'b00000, data_byte[4:0], 6'b000000};
                    rem_next = u2h_pkg::REM_ONE;
                end
                else if (data_byte < u2h_pkg::LEAD_BAD_MIN)
                begin
                    acc_next = {data_byte[3:0], 12'h000};
                    rem_next = u2h_pkg::REM_TWO;
                end
                else
                begin
                    // Lead bytes of four-byte sequences are skipped outright.
                    acc_next = acc_cur;
                    rem_next = rem_cur;
                end
            end
            default:
            begin
                acc_next = '0;
                rem_next = u2h_pkg::REM_NONE;
            end
        endcase

        if (!accept)
        begin
            push.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rem_reg <= u2h_pkg::REM_NONE;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

>>> rtl/u2h_queue.sv
// Short queue of finished character codes between the decoder and the digit
// serializer. Depends on u2h_pkg.
module u2h_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  u2h_pkg::code_push_t           push,
    input  logic                          pop,
    output logic [u2h_pkg::CODE_W-1:0]    head_code,
    output u2h_pkg::queue_status_t        status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [u2h_pkg::CODE_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       do_push;
    logic                       do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_code    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/u2h_back.sv
// Back part of the encoder: sends each queued code as four hex digits, most
// significant first, and marks the fourth. Depends on u2h_pkg.
module u2h_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [u2h_pkg::CODE_W-1:0]    head_code,
    input  u2h_pkg::queue_status_t        status,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast
);

    logic [u2h_pkg::CODE_W-1:0] code_reg;
    logic [u2h_pkg::CODE_W-1:0] code_next;
    logic [1:0]                 idx_reg;
    logic [1:0]                 idx_next;
    logic                       active_reg;
    logic                       active_next;
    logic [3:0]                 nibble;
    logic                       digit_done;

    assign digit_done = active_reg && m_tready;
    // A new code loads as soon as the last digit of the current one is taken.
    assign pop = !status.empty
                 && (!active_reg || (digit_done && idx_reg == u2h_pkg::DIGIT_LAST));

    always_comb
    begin
        code_next   = code_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        if (pop)
        begin
            code_next   = head_code;
            idx_next    = '0;
            active_next = 1'b1;
        end
        else if (digit_done)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == u2h_pkg::DIGIT_LAST)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    nibble = code_reg[15:12];
            2'd1:    nibble = code_reg[11:8];
            2'd2:    nibble = code_reg[7:4];
            default: nibble = code_reg[3:0];
        endcase
    end

    assign m_tvalid = active_reg;
    assign m_tdata  = {1'b0, u2h_pkg::hex_digit(nibble)};
    assign m_tlast  = (idx_reg == u2h_pkg::DIGIT_LAST);

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            active_reg <= active_next;
        end
    end

endmodule

>>> rtl/utf8_to_ucs2_hex_encoder.sv
// UTF-8 to UCS-2 hex encoder, top level. Uses u2h_pkg, u2h_front, u2h_queue, u2h_back.
// The first digit of a completed character is valid once its code has passed the queue
// entry and the back part's code register. Throughput: one digit per cycle while m_tready
// is high, four digits per character, set by the single-digit output channel; bytes enter
// every cycle while the code queue has room. Reset (rst_n low, asynchronous) clears the
// partial sequence, empties the queue and drops any digits in flight.
module utf8_to_ucs2_hex_encoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] start_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] hex_char, [7] zero
    output logic       m_tlast    // last_digit
);

    u2h_pkg::code_push_t        push;
    u2h_pkg::queue_status_t     status;
    logic [u2h_pkg::CODE_W-1:0] head_code;
    logic                       pop;
    logic                       accept;

    assign s_tready = !status.full;
    assign accept   = s_tvalid && s_tready;

    u2h_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_tdata),
        .start_of_text (s_tuser),
        .push          (push)
    );

    u2h_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head_code (head_code),
        .status    (status)
    );

    u2h_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_code (head_code),
        .status    (status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> test/tb_utf8_to_ucs2_hex_encoder.sv
// Testbench for utf8_to_ucs2_hex_encoder: UTF-8 bytes in, ASCII hex digits out.
// A scoreboard class rebuilds each character code and checks every digit in order.
// Depends on rtl/u2h_pkg.sv and the encoder RTL.

// One expected output item: an ASCII hex digit and the flag on the fourth digit.
typedef struct packed {
    logic [u2h_pkg::CHAR_W-1:0] hex_char;
    logic                       last_digit;
} hex_digit_t;

class ucs2_digit_scoreboard;
    logic [u2h_pkg::CODE_W-1:0] partial_code;
    logic [1:0]                 bytes_left;
    hex_digit_t                 expected_digits[$];
    int                         mismatches;
    int                         decoded_bytes;

    function new();
        partial_code = '0;
        bytes_left = u2h_pkg::REM_NONE;
        mismatches = 0;
        decoded_bytes = 0;
    endfunction

    function void queue_code(input logic [u2h_pkg::CODE_W-1:0] code);
        hex_digit_t d;
        logic [3:0] nibble;
        for (int k = 0; k < 4; k++)
        begin
            nibble = code[15 - 4 * k -: 4];
            d.hex_char = u2h_pkg::hex_digit(nibble);
            d.last_digit = (k == 3);
            expected_digits.push_back(d);
        end
    endfunction

    // Called for every accepted input item. Bytes that are skipped as bad lead
    // bytes are not counted in decoded_bytes.
    function void note_byte(input logic [7:0] data_byte, input logic start_of_text);
        int shift;
        if (start_of_text)
        begin
            partial_code = '0;
            bytes_left = u2h_pkg::REM_NONE;
        end
        if (bytes_left != u2h_pkg::REM_NONE)
        begin
            // Continuation bytes are never checked; only the low six bits count.
            shift = (bytes_left == u2h_pkg::REM_TWO) ? 6 : 0;
            partial_code = partial_code | (16'(data_byte[5:0]) << shift);
            bytes_left = bytes_left - 2'd1;
            decoded_bytes++;
            if (bytes_left == u2h_pkg::REM_NONE)
            begin
                queue_code(partial_code);
                partial_code = '0;
            end
        end
        else if (data_byte < u2h_pkg::LEAD_TWO_MIN)
        begin
            partial_code = '0;
            queue_code({8'h00, data_byte});
            decoded_bytes++;
        end
        else if (data_byte < u2h_pkg::LEAD_THREE_MIN)
        begin
            partial_code = {5'b0, data_byte[4:0], 6'b0};
            bytes_left = u2h_pkg::REM_ONE;
            decoded_bytes++;
        end
        else if (data_byte < u2h_pkg::LEAD_BAD_MIN)
        begin
            partial_code = {data_byte[3:0], 12'b0};
            bytes_left = u2h_pkg::REM_TWO;
            decoded_bytes++;
        end
    endfunction

    function void check_digit(input logic [7:0] tdata, input logic tlast);
        hex_digit_t want;
        if (expected_digits.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digit: tdata %h tlast %b", tdata, tlast);
            return;
        end
        want = expected_digits.pop_front();
        if (tdata !== {1'b0, want.hex_char} || tlast !== want.last_digit)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("digit mismatch: expected tdata %h tlast %b, got tdata %h tlast %b",
                         {1'b0, want.hex_char}, want.last_digit, tdata, tlast);
        end
    endfunction

    function int pending();
        return expected_digits.size();
    endfunction
endclass

module tb_utf8_to_ucs2_hex_encoder;

    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_BYTES = 84;
    localparam int HOLD_CYCLES = 200;

    // Directed text, {start_of_text, data_byte} per item.
    localparam logic [8:0] DIRECTED_TEXT [24] = '{
        9'h100, 9'h07F,                 // zero byte with start of text, highest ASCII
        9'h0C3, 9'h0A9,                 // two-byte character
        9'h080, 9'h080,                 // lowest two-byte lead
        9'h0DF, 9'h0FF,                 // highest two-byte lead, all-ones continuation
        9'h0E0, 9'h080, 9'h080,         // lowest three-byte lead
        9'h0EF, 9'h0BF, 9'h0BF,         // gives FFFF
        9'h0F0, 9'h0FF,                 // bad lead bytes, skipped
        9'h0C2, 9'h041,                 // ASCII value used as continuation
        9'h0E2, 9'h0F5, 9'h0E0,         // lead-like values used as continuation
        9'h0E4, 9'h0B8, 9'h141          // unfinished sequence dropped by start of text
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    ucs2_digit_scoreboard digit_board = new();
    logic rx_hold;
    int   bytes_sent;
    int   quiet_cycles;

    utf8_to_ucs2_hex_encoder uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sender side: offers one byte, with a random gap before it when idling is on.
    logic tx_idle = 1'b1;

    task automatic send_byte(input logic [7:0] data_byte, input logic start_of_text);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_idle = ~tx_idle;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data_byte;
        s_tuser <= start_of_text;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        digit_board.note_byte(data_byte, start_of_text);
        bytes_sent++;
    endtask

    function automatic logic [7:0] continuation_byte();
        // Mostly well-formed continuation bytes, sometimes any value at all.
        if ($urandom_range(0, 5) == 0)
            return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic send_random_text();
        int first_count;
        int pick;
        logic sot;
        first_count = digit_board.decoded_bytes;
        while (digit_board.decoded_bytes - first_count < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 9);
            sot = ($urandom_range(0, 7) == 0);
            if (pick <= 3)
            begin
                send_byte(8'($urandom_range(0, 127)), sot);
            end
            else if (pick <= 5)
            begin
                send_byte(8'($urandom_range(8'h80, 8'hDF)), sot);
                send_byte(continuation_byte(), 1'b0);
            end
            else if (pick <= 7)
            begin
                send_byte(8'($urandom_range(8'hE0, 8'hEF)), sot);
                send_byte(continuation_byte(), 1'b0);
                send_byte(continuation_byte(), 1'b0);
            end
            else if (pick == 8)
            begin
                send_byte(8'($urandom_range(0, 255)), sot);
            end
            else
            begin
                // A sequence cut short by the start of a new text.
                send_byte(8'($urandom_range(8'h80, 8'hEF)), sot);
                if ($urandom_range(0, 1) == 1)
                    send_byte(continuation_byte(), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        bytes_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED_TEXT[i])
            send_byte(DIRECTED_TEXT[i][7:0], DIRECTED_TEXT[i][8]);
        send_random_text();
        s_tvalid <= 1'b0;
        while (digit_board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (digit_board.mismatches == 0)
            $display("utf8_to_ucs2_hex_encoder test passed");
        else
            $display("utf8_to_ucs2_hex_encoder test failed");
        $finish;
    end

    // Receiver side: takes digits and, when idling is on, stalls a random number of cycles after each.
    initial
    begin
        int stall_left;
        logic rx_idle;
        m_tready = 1'b0;
        stall_left = 0;
        rx_idle = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                digit_board.check_digit(m_tdata, m_tlast);
                if ($urandom_range(0, 15) == 0)
                    rx_idle = ~rx_idle;
                stall_left = rx_idle ? $urandom_range(0, 17) : 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            m_tready <= (stall_left == 0) && !rx_hold;
        end
    end

    // Long receiver hold-off while the sender keeps going, so the queue fills
    // and the input side has to stall.
    initial
    begin
        rx_hold = 1'b0;
        wait (bytes_sent >= 40);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("utf8_to_ucs2_hex_encoder test failed");
                $finish;
            end
        end
    end

endmodule

>>> utf8_to_ucs2_hex_encoder.f
rtl/u2h_pkg.sv
rtl/u2h_front.sv
rtl/u2h_queue.sv
rtl/u2h_back.sv
rtl/utf8_to_ucs2_hex_encoder.sv
test/tb_utf8_to_ucs2_hex_encoder.sv
